// ----- hw/rtl/turb_pkg.sv -----
// Package for the tagged URL rebuilder: tag codes, component codes, the
// classified request record and queue status. No dependencies.

package turb_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] URL_END       = 8'h00;
   localparam logic [7:0] MARK_USER     = 8'h11;
   localparam logic [7:0] MARK_PASSWORD = 8'h12;
   localparam logic [7:0] MARK_HOST     = 8'h13;
   localparam logic [7:0] MARK_PORT     = 8'h14;
   localparam logic [7:0] MARK_PATH     = 8'h15;
   localparam logic [7:0] MARK_QUERY    = 8'h16;
   localparam logic [7:0] MARK_FRAGMENT = 8'h17;
   localparam logic [7:0] MARK_SKIP     = 8'h18;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_QUEST = 8'h3F;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_AT    = 8'h40;

   localparam logic [2:0] COMP_SCHEME   = 3'd0;
   localparam logic [2:0] COMP_USER     = 3'd1;
   localparam logic [2:0] COMP_PASSWORD = 3'd2;
   localparam logic [2:0] COMP_HOST     = 3'd3;

   localparam logic [3:0][7:0] LEAD_CHAR = {CHAR_HASH, CHAR_QUEST, CHAR_SLASH, CHAR_COLON};

   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] text;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ----- hw/rtl/turb_front.sv -----
// Front end: accepts tagged bytes, tracks the URL component and turns each
// request into a record of up to three output bytes. Uses turb_pkg.

module turb_front
   import turb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_tagged_byte,
   input  q_status_type q_status,
   output logic         push,
   output rec_type      push_rec
);

   logic [2:0] comp_ff;
   logic [2:0] comp_in;
   logic       accept;
   rec_type    rec;

   assign req_stall = q_status.full;
   assign accept    = req_valid & ~q_status.full;

   always_comb begin
      rec     = '0;
      comp_in = comp_ff;
      unique case (req_tagged_byte) inside
         URL_END: begin
            rec.count   = 2'd1;
            rec.text[0] = URL_END;
            comp_in     = COMP_SCHEME;
         end
         MARK_SKIP: begin
            rec.count = 2'd0;
         end
         MARK_USER: begin
            rec.count = 2'd3;
            rec.text  = {CHAR_SLASH, CHAR_SLASH, CHAR_COLON};
            comp_in   = COMP_USER;
         end
         MARK_PASSWORD: begin
            rec.count   = 2'd1;
            rec.text[0] = CHAR_COLON;
            comp_in     = COMP_PASSWORD;
         end
         MARK_HOST: begin
            if (comp_ff == COMP_SCHEME) begin
               rec.count = 2'd3;
               rec.text  = {CHAR_SLASH, CHAR_SLASH, CHAR_COLON};
            end else begin
               rec.count   = 2'd1;
               rec.text[0] = CHAR_AT;
            end
            comp_in = COMP_HOST;
         end
         MARK_PORT, MARK_PATH, MARK_QUERY, MARK_FRAGMENT: begin
            if (comp_ff == COMP_SCHEME) begin
               rec.count   = 2'd2;
               rec.text[0] = CHAR_COLON;
               rec.text[1] = LEAD_CHAR[req_tagged_byte[1:0]];
            end else if (comp_ff == COMP_USER || comp_ff == COMP_PASSWORD) begin
               rec.count   = 2'd2;
               rec.text[0] = CHAR_AT;
               rec.text[1] = LEAD_CHAR[req_tagged_byte[1:0]];
            end else begin
               rec.count   = 2'd1;
               rec.text[0] = LEAD_CHAR[req_tagged_byte[1:0]];
            end
            comp_in = req_tagged_byte[2:0];
         end
         default: begin
            rec.count   = 2'd1;
            rec.text[0] = req_tagged_byte;
         end
      endcase
   end

   assign push     = accept & (rec.count != 2'd0);
   assign push_rec = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_ff <= COMP_SCHEME;
      end else if (accept) begin
         comp_ff <= comp_in;
      end
   end

endmodule

// ----- hw/rtl/turb_queue.sv -----
// Short FIFO of classified records between front and back end.
// Uses turb_pkg for the record and status types.

module turb_queue
   import turb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rec_type      push_rec,
   input  logic         pop,
   output rec_type      pop_rec,
   output q_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   rec_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   assign q_status.full  = (cnt_ff == FULL_CNT);
   assign q_status.empty = (cnt_ff == '0);
   assign pop_rec        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push & ~pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop & ~push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- hw/rtl/turb_back.sv -----
// Back end: takes records from the queue and sends their bytes one per
// cycle while rsp_stall is low, through a registered response stage. Uses turb_pkg.

module turb_back
   import turb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  rec_type      pop_rec,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_url_byte,
   output logic         rsp_run_end
);

   rec_type    hold_ff;
   logic       busy_ff;
   logic       busy_in;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic       rsp_valid_ff;
   logic [7:0] rsp_url_byte_ff;
   logic       rsp_run_end_ff;
   logic       out_free;
   logic       last;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign last     = (idx_ff == hold_ff.count - 2'd1);
   assign pop      = ~q_status.empty & (~busy_ff | (out_free & last));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (out_free & busy_ff) begin
         idx_in = idx_ff + 2'd1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         hold_ff <= pop_rec;
      end
      if (out_free & busy_ff) begin
         rsp_url_byte_ff <= hold_ff.text[idx_ff];
         rsp_run_end_ff  <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         if (out_free) begin
            rsp_valid_ff <= busy_ff;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_url_byte = rsp_url_byte_ff;
   assign rsp_run_end  = rsp_run_end_ff;

endmodule

// ----- hw/rtl/tagged_url_rebuilder_core.sv -----
// Tagged URL rebuilder top level: front end, record queue and back end.
// Depends on turb_pkg, turb_front, turb_queue and turb_back.
//
// Usage:
//   Request channel (req_valid, req_stall, req_tagged_byte) takes one tagged
//   URL byte per request. Tags 0x11..0x17 become URL delimiters, 0x18 is
//   dropped, 0x00 ends the URL, any other byte is copied.
//   Response channel (rsp_valid, rsp_stall, rsp_url_byte, rsp_run_end)
//   gives zero to three bytes per request; rsp_run_end marks the last byte
//   of each request.
//   A request's bytes pass through the record queue, the back end's hold
//   register and the response register.
//   Throughput: the single byte-wide response register sends one byte per
//   cycle while rsp_stall is low; a request produces 1 to 3 bytes, and
//   skip tags produce no response byte. Requests are accepted every cycle
//   while the record queue has room.
//   Reset clears the component state to scheme and empties the queue and
//   the response register.
//   While rsp_stall is high the response holds; the queue fills and then
//   req_stall rises.

module tagged_url_rebuilder_core
   import turb_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_tagged_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_url_byte,
   output logic       rsp_run_end
);

   q_status_type q_status;
   logic         push;
   logic         pop;
   rec_type      push_rec;
   rec_type      pop_rec;

   turb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_tagged_byte (req_tagged_byte),
      .q_status        (q_status),
      .push            (push),
      .push_rec        (push_rec)
   );

   turb_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .q_status (q_status)
   );

   turb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .pop_rec      (pop_rec),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_url_byte (rsp_url_byte),
      .rsp_run_end  (rsp_run_end)
   );

endmodule

// ----- test/tagged_url_rebuilder_core_test.sv -----
// Self-checking testbench for tagged_url_rebuilder_core: directed and random tagged URLs,
// with a predictor of the rebuilt text checked byte for byte under random idling.
// Depends on turb_pkg and the tagged_url_rebuilder_core RTL.

module tagged_url_rebuilder_core_test;
   import turb_pkg::*;

   typedef struct packed {
      logic [7:0] url_byte;
      logic       run_end;
   } url_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_tagged_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_url_byte;
   logic       rsp_run_end;

   logic [7:0]   pending_tagged [$];
   url_char_type expected_url [$];
   logic [2:0]   url_component = COMP_SCHEME;
   logic         req_taken = 1'b0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           error_count = 0;

   tagged_url_rebuilder_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_tagged_byte (req_tagged_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_url_byte    (rsp_url_byte),
      .rsp_run_end     (rsp_run_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Work out the URL text that one tagged byte turns into.
   task automatic rebuild_url(input logic [7:0] tag_byte);
      logic [7:0]   text [$];
      url_char_type item;
      case (tag_byte)
         URL_END: begin
            text.push_back(URL_END);
            url_component = COMP_SCHEME;
         end
         MARK_SKIP: ;
         MARK_USER: begin
            text.push_back(CHAR_COLON);
            text.push_back(CHAR_SLASH);
            text.push_back(CHAR_SLASH);
            url_component = COMP_USER;
         end
         MARK_PASSWORD: begin
            text.push_back(CHAR_COLON);
            url_component = COMP_PASSWORD;
         end
         MARK_HOST: begin
            if (url_component == COMP_SCHEME) begin
               text.push_back(CHAR_COLON);
               text.push_back(CHAR_SLASH);
               text.push_back(CHAR_SLASH);
            end else begin
               text.push_back(CHAR_AT);
            end
            url_component = COMP_HOST;
         end
         MARK_PORT, MARK_PATH, MARK_QUERY, MARK_FRAGMENT: begin
            if (url_component == COMP_SCHEME)
               text.push_back(CHAR_COLON);
            else if (url_component == COMP_USER || url_component == COMP_PASSWORD)
               text.push_back(CHAR_AT);
            case (tag_byte)
               MARK_PORT:  text.push_back(CHAR_COLON);
               MARK_PATH:  text.push_back(CHAR_SLASH);
               MARK_QUERY: text.push_back(CHAR_QUEST);
               default:    text.push_back(CHAR_HASH);
            endcase
            url_component = tag_byte[2:0];
         end
         default: text.push_back(tag_byte);
      endcase
      for (int k = 0; k < text.size(); k++) begin
         item.url_byte = text[k];
         item.run_end  = (k == text.size() - 1);
         expected_url.push_back(item);
      end
   endtask

   function automatic logic [7:0] random_text_byte();
      logic [7:0] b;
      do begin
         if ($urandom_range(3) != 0)
            b = 8'($urandom_range(8'h20, 8'h7E));
         else
            b = 8'($urandom_range(1, 255));
      end while (b == URL_END || (b >= MARK_USER && b <= MARK_SKIP));
      return b;
   endfunction

   task automatic queue_text(input int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(15) == 0)
            pending_tagged.push_back(MARK_SKIP);
         pending_tagged.push_back(random_text_byte());
      end
   endtask

   task automatic queue_url();
      queue_text($urandom_range(0, 5));
      if ($urandom_range(2) == 0) begin
         pending_tagged.push_back(MARK_USER);
         queue_text($urandom_range(0, 4));
         if ($urandom_range(1)) begin
            pending_tagged.push_back(MARK_PASSWORD);
            queue_text($urandom_range(0, 4));
         end
      end
      if ($urandom_range(4) != 0) begin
         pending_tagged.push_back(MARK_HOST);
         queue_text($urandom_range(0, 6));
      end
      if ($urandom_range(2) == 0) begin
         pending_tagged.push_back(MARK_PORT);
         queue_text($urandom_range(0, 3));
      end
      if ($urandom_range(1)) begin
         pending_tagged.push_back(MARK_PATH);
         queue_text($urandom_range(0, 6));
      end
      if ($urandom_range(2) == 0) begin
         pending_tagged.push_back(MARK_QUERY);
         queue_text($urandom_range(0, 4));
      end
      if ($urandom_range(2) == 0) begin
         pending_tagged.push_back(MARK_FRAGMENT);
         queue_text($urandom_range(0, 3));
      end
      pending_tagged.push_back(URL_END);
   endtask

   task automatic queue_noise(input int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(1))
            pending_tagged.push_back(8'($urandom_range(0, 255)));
         else
            pending_tagged.push_back(8'($urandom_range(8'h10, 8'h18)));
      end
   endtask

   task automatic fill_phase(input int count);
      while (pending_tagged.size() < count) begin
         if ($urandom_range(4) == 0)
            queue_noise($urandom_range(1, 12));
         else
            queue_url();
      end
   endtask

   task automatic wait_drained();
      while (pending_tagged.size() != 0 || req_valid || expected_url.size() != 0)
         @(posedge clock);
   endtask

   // Request driver: hold the payload until taken, then advance.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_tagged.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid       <= 1'b1;
            req_tagged_byte <= pending_tagged.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Monitor: predict on each accepted request, check each accepted response.
   always @(posedge clock) begin
      url_char_type want;
      if (reset) begin
         req_taken     <= 1'b0;
         url_component = COMP_SCHEME;
         expected_url.delete();
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            rebuild_url(req_tagged_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_url.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h", rsp_url_byte));
            end else begin
               want = expected_url.pop_front();
               if (rsp_url_byte !== want.url_byte)
                  report_mismatch($sformatf("url_byte %02h, want %02h",
                                            rsp_url_byte, want.url_byte));
               if (rsp_run_end !== want.run_end)
                  report_mismatch($sformatf("run_end %b, want %b on byte %02h",
                                            rsp_run_end, want.run_end, want.url_byte));
            end
         end
      end
   end

   initial begin
      #4000000;
      $display("tagged_url_rebuilder_core_test failed");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: byte extremes, every tag, and delimiter tags from several kinds of component
      pending_tagged = '{URL_END, 8'hFF, 8'h01, 8'h10, 8'h19, MARK_SKIP,
                         MARK_USER, 8'h75, MARK_PASSWORD, 8'h70, MARK_HOST, 8'h68,
                         MARK_PORT, 8'h38, MARK_PATH, MARK_QUERY, MARK_FRAGMENT,
                         MARK_HOST, URL_END, MARK_HOST, URL_END, MARK_PATH, URL_END,
                         MARK_USER, MARK_QUERY, MARK_PASSWORD, MARK_FRAGMENT, URL_END};
      send_idle_pct  = 6;
      recv_stall_pct = 86;
      fill_phase(160);
      wait_drained();

      send_idle_pct  = 86;
      recv_stall_pct = 6;
      fill_phase(150);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fill_phase(150);
      wait_drained();

      repeat (20) @(posedge clock);
      @(negedge clock);
      if (error_count == 0 && expected_url.size() == 0)
         $display("tagged_url_rebuilder_core_test passed");
      else
         $display("tagged_url_rebuilder_core_test failed");
      $finish;
   end

endmodule
